/* src/ssetc_pkg.sv */
// ----------------------------------------------------------------------------
// ssetc_pkg
// shared constants for the subarray sum counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssetc_pkg;

  localparam int SUM_BITS          = 32;
  localparam int COUNT_BITS        = 20;
  localparam int MAX_ITEMS_DEF     = 1024;
  localparam int TABLE_DEPTH_DEF   = 2048;
  localparam int ELEMENT_BITS_DEF  = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 20'hFFFFF;
  localparam logic [SUM_BITS-1:0]   HASH_MULT = 32'h9E3779B1;

endpackage

/* src/ssetc_if.sv */
// ----------------------------------------------------------------------------
// ssetc channel interfaces
// valid/ready channels for element, result and target words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ssetc_in_if #(
  parameter int ELEMENT_BITS = ssetc_pkg::ELEMENT_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [ELEMENT_BITS-1:0] element_value;
  logic                           last_item;

  modport source (output valid, output element_value, output last_item, input ready);
  modport sink   (input valid, input element_value, input last_item, output ready);
endinterface

interface ssetc_out_if;
  import ssetc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] matching_count;
  logic                  table_overflow;
  logic                  last_result;

  modport source (output valid, output matching_count, output table_overflow,
                  output last_result, input ready);
  modport sink   (input valid, input matching_count, input table_overflow,
                  input last_result, output ready);
endinterface

interface ssetc_cfg_if;
  import ssetc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SUM_BITS-1:0] target_sum;

  modport source (output valid, output target_sum, input ready);
  modport sink   (input valid, input target_sum, output ready);
endinterface

/* src/ssetc_home_unit.sv */
// ----------------------------------------------------------------------------
// ssetc_home_unit
// home slot of a key: multiplicative hash, then reduction modulo table depth
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssetc_home_unit #(
  parameter int TABLE_DEPTH = ssetc_pkg::TABLE_DEPTH_DEF,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ssetc_pkg::SUM_BITS-1:0] key,
  output logic                          done,
  output logic [AW-1:0]                 slot
);
  import ssetc_pkg::*;

  localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam int CW      = $clog2(SUM_BITS);

  typedef enum logic [1:0] {H_IDLE, H_MUL, H_DIV} hstate_t;

  hstate_t             state_r;
  logic [SUM_BITS-1:0] prod_r;
  logic [AW-1:0]       rem_r;
  logic [CW-1:0]       cnt_r;
  logic                done_r;
  logic [AW-1:0]       slot_r;
  logic [AW:0]         shifted;
  logic [AW:0]         reduced;

  assign shifted = {rem_r, prod_r[SUM_BITS-1]};
  assign reduced = (shifted >= (AW+1)'(TABLE_DEPTH)) ? shifted - (AW+1)'(TABLE_DEPTH)
                                                     : shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        H_IDLE: begin
          if (start) begin
            prod_r  <= key * HASH_MULT;
            state_r <= H_MUL;
          end
        end
        H_MUL: begin
          if (IS_POW2) begin
            slot_r  <= prod_r[AW-1:0];
            done_r  <= 1'b1;
            state_r <= H_IDLE;
          end else begin
            rem_r   <= '0;
            cnt_r   <= CW'(SUM_BITS - 1);
            state_r <= H_DIV;
          end
        end
        H_DIV: begin
          rem_r  <= AW'(reduced);
          prod_r <= {prod_r[SUM_BITS-2:0], 1'b0};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            slot_r  <= AW'(reduced);
            done_r  <= 1'b1;
            state_r <= H_IDLE;
          end
        end
        default: state_r <= H_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign slot = slot_r;

endmodule

/* src/ssetc_table_mem.sv */
// ----------------------------------------------------------------------------
// ssetc_table_mem
// occurrence table storage, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssetc_table_mem #(
  parameter int DEPTH = ssetc_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/subarray_sum_equals_target_counter_core.sv */
// ----------------------------------------------------------------------------
// subarray_sum_equals_target_counter_core: per word, one hash and probe pass for the
// new prefix, one for prefix minus target, then a table write; a probe step is a read
// then a check, and the hash reduces by mask (power-of-two depth) or bit-serial division
// reset and each last word start a table clearing pass, no input taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module subarray_sum_equals_target_counter_core #(
  parameter int MAX_ITEMS    = ssetc_pkg::MAX_ITEMS_DEF,
  parameter int TABLE_DEPTH  = ssetc_pkg::TABLE_DEPTH_DEF,
  parameter int ELEMENT_BITS = ssetc_pkg::ELEMENT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ssetc_in_if.sink    in_ch,
  ssetc_out_if.source out_ch,
  ssetc_cfg_if.sink   cfg_ch
);
  import ssetc_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(MAX_ITEMS + 2);
  localparam int IW  = $clog2(MAX_ITEMS + 1);
  localparam int DW  = 1 + SUM_BITS + CW;
  localparam int SW  = ((COUNT_BITS > CW) ? COUNT_BITS : CW) + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_RD, S_CHK, S_WRITE, S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic [SUM_BITS-1:0]   target_r;
  logic [SUM_BITS-1:0]   prefix_r, prefix_nxt;
  logic [SUM_BITS-1:0]   next_r, next_nxt;
  logic [SUM_BITS-1:0]   key_r, key_nxt;
  logic [COUNT_BITS-1:0] running_r, running_nxt;
  logic [IW-1:0]         items_r, items_nxt;
  logic                  overflow_r, overflow_nxt;
  logic                  last_r, last_nxt;
  logic                  phase_r, phase_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [AW-1:0]         steps_r, steps_nxt;
  logic [AW-1:0]         ins_pos_r, ins_pos_nxt;
  logic                  ins_valid_r, ins_valid_nxt;
  logic [CW-1:0]         ins_count_r, ins_count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COUNT_BITS-1:0] out_count_r, out_count_nxt;
  logic                  out_ovf_r, out_ovf_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  hstart;
  logic [SUM_BITS-1:0]   hkey;
  logic                  hdone;
  logic [AW-1:0]         hslot;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DW-1:0]         mem_wdata;
  logic [DW-1:0]         mem_rdata;

  logic                  rd_valid;
  logic [SUM_BITS-1:0]   rd_key;
  logic [CW-1:0]         rd_count;
  logic                  hit;
  logic                  probe_end;
  logic [SUM_BITS-1:0]   elem_ext;
  logic [SUM_BITS-1:0]   next_sum;
  logic [SUM_BITS-1:0]   want;
  logic [CW-1:0]         add;
  logic [SW-1:0]         sat_sum;
  logic [COUNT_BITS-1:0] sat_count;
  logic                  in_accept;

  ssetc_home_unit #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hstart),
    .key   (hkey),
    .done  (hdone),
    .slot  (hslot)
  );

  ssetc_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (pos_r),
    .rdata (mem_rdata)
  );

  assign rd_valid  = mem_rdata[DW-1];
  assign rd_key    = mem_rdata[DW-2:CW];
  assign rd_count  = mem_rdata[CW-1:0];
  assign hit       = !rd_valid || (rd_key == key_r);
  assign probe_end = (steps_r == AW'(TABLE_DEPTH - 1));

  assign elem_ext  = SUM_BITS'(signed'(in_ch.element_value[ELEMENT_BITS-1:0]));
  assign next_sum  = prefix_r + elem_ext;
  assign want      = key_r - target_r;
  assign add       = (hit && rd_valid) ? rd_count : '0;
  assign sat_sum   = SW'(running_r) + SW'(add);
  assign sat_count = (sat_sum > SW'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(sat_sum);

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    prefix_nxt    = prefix_r;
    next_nxt      = next_r;
    key_nxt       = key_r;
    running_nxt   = running_r;
    items_nxt     = items_r;
    overflow_nxt  = overflow_r;
    last_nxt      = last_r;
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    steps_nxt     = steps_r;
    ins_pos_nxt   = ins_pos_r;
    ins_valid_nxt = ins_valid_r;
    ins_count_nxt = ins_count_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_count_nxt = out_count_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    hstart        = 1'b0;
    hkey          = next_sum;
    mem_we        = 1'b0;
    mem_waddr     = ins_pos_r;
    mem_wdata     = '0;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        // slot zero is the home of key zero, seen once
        mem_wdata = (clr_r == '0) ? {1'b1, {SUM_BITS{1'b0}}, CW'(1)} : '0;
        if (clr_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          last_nxt = in_ch.last_item;
          if (overflow_r) begin
            state_nxt = S_DONE;
          end else if (items_r >= IW'(MAX_ITEMS)) begin
            overflow_nxt = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            hstart    = 1'b1;
            hkey      = next_sum;
            next_nxt  = next_sum;
            key_nxt   = next_sum;
            phase_nxt = 1'b0;
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hdone) begin
          pos_nxt   = hslot;
          steps_nxt = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!phase_r && hit) begin
          ins_pos_nxt   = pos_r;
          ins_valid_nxt = rd_valid;
          ins_count_nxt = rd_count;
          phase_nxt     = 1'b1;
          key_nxt       = want;
          hstart        = 1'b1;
          hkey          = want;
          state_nxt     = S_HASH;
        end else if (phase_r && (hit || probe_end)) begin
          running_nxt = sat_count;
          state_nxt   = S_WRITE;
        end else if (probe_end) begin
          // table full and new prefix has no slot
          overflow_nxt = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          pos_nxt   = (pos_r == AW'(TABLE_DEPTH - 1)) ? '0 : pos_r + 1'b1;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_WRITE: begin
        mem_we     = 1'b1;
        mem_waddr  = ins_pos_r;
        mem_wdata  = {1'b1, next_r, (ins_valid_r ? ins_count_r : CW'(0)) + CW'(1)};
        prefix_nxt = next_r;
        items_nxt  = items_r + 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = running_r;
          out_ovf_nxt   = overflow_r;
          out_last_nxt  = last_r;
          if (last_r) begin
            prefix_nxt   = '0;
            running_nxt  = '0;
            items_nxt    = '0;
            overflow_nxt = 1'b0;
            clr_nxt      = '0;
            state_nxt    = S_CLEAR;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      target_r    <= '0;
      prefix_r    <= '0;
      running_r   <= '0;
      items_r     <= '0;
      overflow_r  <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      prefix_r    <= prefix_nxt;
      running_r   <= running_nxt;
      items_r     <= items_nxt;
      overflow_r  <= overflow_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        target_r <= cfg_ch.target_sum;
      end
    end
    next_r      <= next_nxt;
    key_r       <= key_nxt;
    last_r      <= last_nxt;
    pos_r       <= pos_nxt;
    steps_r     <= steps_nxt;
    ins_pos_r   <= ins_pos_nxt;
    ins_valid_r <= ins_valid_nxt;
    ins_count_r <= ins_count_nxt;
    out_count_r <= out_count_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.matching_count = out_count_r;
  assign out_ch.table_overflow = out_ovf_r;
  assign out_ch.last_result    = out_last_r;

`ifndef SYNTHESIS
  // an accepted word always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r != S_IDLE)
    else $error("accepted word left block idle");

  // element count never runs past the array limit
  a_items_bound: assert property (@(posedge clk) disable iff (!rst_n)
    items_r <= IW'(MAX_ITEMS))
    else $error("element count beyond limit");

  // table written with a new prefix only for an unfrozen array
  a_write_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE |-> !overflow_r && phase_r)
    else $error("table write on frozen array");

  // match total only grows within an array
  a_running_mono: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_CLEAR && $past(state_r) != S_CLEAR |-> running_r >= $past(running_r))
    else $error("match total decreased");
`endif

endmodule

/* dv/subarray_sum_equals_target_counter_checker.sv */
// ----------------------------------------------------------------------------
// subarray_sum_equals_target_counter_checker
// watches the element, result and target channels, keeps its own prefix sum
// and occurrence table, and compares every result word against the count
// that the accepted elements call for
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module subarray_sum_equals_target_counter_checker #(
  parameter int MAX_ITEMS    = ssetc_pkg::MAX_ITEMS_DEF,
  parameter int TABLE_DEPTH  = ssetc_pkg::TABLE_DEPTH_DEF,
  parameter int ELEMENT_BITS = ssetc_pkg::ELEMENT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ssetc_in_if         in_mon,
  ssetc_out_if        out_mon,
  ssetc_cfg_if        cfg_mon,
  output int unsigned fail_count,
  output int unsigned pending
);
  import ssetc_pkg::*;

  localparam logic [31:0] GOLDEN_MULT = 32'd2654435761;
  localparam int          PRINT_CAP   = 200;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic                  overflow;
    logic                  last;
  } tally_t;

  tally_t tally_q[$];

  logic [SUM_BITS-1:0]   target_r;
  logic [SUM_BITS-1:0]   prefix_r;
  logic [COUNT_BITS-1:0] matches_r;
  int unsigned           taken_r;
  logic                  frozen_r;
  logic                  slot_used [TABLE_DEPTH];
  logic [SUM_BITS-1:0]   slot_key  [TABLE_DEPTH];
  logic [31:0]           slot_cnt  [TABLE_DEPTH];
  int unsigned           errs = 0;

  function automatic int unsigned home_of(logic [SUM_BITS-1:0] key);
    logic [31:0] prod;
    prod = key * GOLDEN_MULT;
    return prod % TABLE_DEPTH;
  endfunction

  // slot holding key, else first free slot on its path, else TABLE_DEPTH
  function automatic int unsigned find_slot(logic [SUM_BITS-1:0] key);
    int unsigned pos;
    pos = home_of(key);
    for (int n = 0; n < TABLE_DEPTH; n++) begin
      if (!slot_used[pos] || slot_key[pos] == key) return pos;
      pos = (pos + 1) % TABLE_DEPTH;
    end
    return TABLE_DEPTH;
  endfunction

  function automatic void clear_sums();
    int unsigned s;
    prefix_r  = '0;
    matches_r = '0;
    taken_r   = 0;
    frozen_r  = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
      slot_cnt[i]  = '0;
    end
    s = home_of('0);
    slot_used[s] = 1'b1;
    slot_cnt[s]  = 32'd1;
  endfunction

  function automatic void tally_word(logic [ELEMENT_BITS-1:0] elem, logic last);
    logic [SUM_BITS-1:0] ext;
    logic [SUM_BITS-1:0] nxt;
    logic [SUM_BITS-1:0] want;
    int unsigned         ins;
    int unsigned         look;
    logic [31:0]         add;
    tally_t              t;
    ext = {{(SUM_BITS-ELEMENT_BITS){elem[ELEMENT_BITS-1]}}, elem};
    if (!frozen_r) begin
      if (taken_r >= MAX_ITEMS) begin
        frozen_r = 1'b1;
      end else begin
        nxt = prefix_r + ext;
        ins = find_slot(nxt);
        if (ins >= TABLE_DEPTH) begin
          frozen_r = 1'b1;
        end else begin
          want = nxt - target_r;
          look = find_slot(want);
          add  = '0;
          if (look < TABLE_DEPTH && slot_used[look]) add = slot_cnt[look];
          if (add > 32'(COUNT_MAX) - 32'(matches_r)) matches_r = COUNT_MAX;
          else matches_r = matches_r + add[COUNT_BITS-1:0];
          if (!slot_used[ins]) begin
            slot_used[ins] = 1'b1;
            slot_key[ins]  = nxt;
            slot_cnt[ins]  = '0;
          end
          if (slot_cnt[ins] != 32'hFFFF_FFFF) slot_cnt[ins] = slot_cnt[ins] + 1;
          prefix_r = nxt;
          taken_r++;
        end
      end
    end
    t.count    = matches_r;
    t.overflow = frozen_r;
    t.last     = last;
    tally_q.push_back(t);
    if (last) clear_sums();
  endfunction

  task automatic report(string msg);
    if (errs < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
    errs++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    tally_t got;
    tally_t want_t;
    if (!rst_n) begin
      target_r = '0;
      clear_sums();
      tally_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) target_r = cfg_mon.target_sum;
      if (in_mon.valid && in_mon.ready) tally_word(in_mon.element_value, in_mon.last_item);
      if (out_mon.valid && out_mon.ready) begin
        got.count    = out_mon.matching_count;
        got.overflow = out_mon.table_overflow;
        got.last     = out_mon.last_result;
        if (tally_q.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          want_t = tally_q.pop_front();
          check_field("matching_count", 32'(got.count), 32'(want_t.count));
          check_field("table_overflow", 32'(got.overflow), 32'(want_t.overflow));
          check_field("last_result", 32'(got.last), 32'(want_t.last));
        end
      end
    end
    fail_count <= errs;
    pending    <= tally_q.size();
  end

endmodule

/* dv/subarray_sum_equals_target_counter_core_tb.sv */
// ----------------------------------------------------------------------------
// subarray_sum_equals_target_counter_core_tb
// drives signed element words in arrays of random length under several
// idling patterns and target settings, including extreme targets, a long
// receiver hold and one array past the item limit; the checker beside the
// block predicts and compares every result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module subarray_sum_equals_target_counter_core_tb;
  import ssetc_pkg::*;

  localparam int QUIET_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int TAIL_CYCLES   = 200;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 8;
  localparam int LONG_ARRAY    = MAX_ITEMS_DEF + 6;

  typedef enum int {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idle_mode_e;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  int          src_idle   = 0;
  int          sink_stall = 0;
  int          hold_req   = 0;
  int          hold_ack   = 0;
  int          hold_left  = 0;
  int          quiet      = 0;

  ssetc_in_if  in_ch ();
  ssetc_out_if out_ch ();
  ssetc_cfg_if cfg_ch ();

  subarray_sum_equals_target_counter_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  subarray_sum_equals_target_counter_checker i_count_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls plus one long hold on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
        hold_ack     <= hold_req;
        hold_left    <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic set_idle(idle_mode_e m);
    case (m)
      IDLE_NONE: begin
        src_idle = 0;
        sink_stall = 0;
      end
      IDLE_SOURCE: begin
        src_idle = 79;
        sink_stall = 0;
      end
      IDLE_SINK: begin
        src_idle = 0;
        sink_stall = 79;
      end
      default: begin
        src_idle = 12;
        sink_stall = 12;
      end
    endcase
  endtask

  task automatic write_target(logic [SUM_BITS-1:0] v);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.target_sum <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // leaves valid high so back-to-back words need no second assignment
  task automatic send_word(logic [ELEMENT_BITS_DEF-1:0] v, logic last);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.element_value <= v;
    in_ch.last_item     <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [ELEMENT_BITS_DEF-1:0] rand_element();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(8)) - 16'd4;
    if (r < 85) return 16'($urandom_range(600)) - 16'd300;
    if (r < 93) return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    return 16'($urandom);
  endfunction

  function automatic int rand_length();
    if ($urandom_range(9) == 0) return $urandom_range(60, 13);
    return $urandom_range(12, 1);
  endfunction

  task automatic send_array(int len);
    for (int i = 0; i < len; i++) send_word(rand_element(), i == len - 1);
  endtask

  initial begin
    int sent;
    int len;
    logic [SUM_BITS-1:0] tgt;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.element_value <= '0;
    in_ch.last_item     <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.target_sum   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero runs, element extremes, single word, extreme targets
    set_idle(IDLE_NONE);
    write_target('0);
    send_word(16'h0000, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h0000, 1'b1);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'h0000, 1'b1);
    send_word(16'h8000, 1'b1);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_target(32'h8000_0000);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b1);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_target(32'h7FFF_FFFF);
    send_word(16'h0005, 1'b0);
    send_word(16'hFFFB, 1'b1);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_target(32'd3);
    send_word(16'h0001, 1'b0);
    send_word(16'h0002, 1'b0);
    send_word(16'h0003, 1'b0);
    send_word(16'hFFFD, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h0003, 1'b1);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_target(32'hFFFF_FFFF);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'hFFFF, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
      set_idle(idle_mode_e'(p % 4));
      case (p)
        4:       tgt = 32'h7FFF_FFFF;
        6:       tgt = 32'h8000_0000;
        7:       tgt = $urandom;
        default: tgt = 32'($urandom_range(12)) - 32'd6;
      endcase
      write_target(tgt);
      if (p == 0) hold_req <= hold_req + 1;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        len = rand_length();
        send_array(len);
        sent += len;
      end
      // array past the item limit, count freezes
      if (p == 0) send_array(LONG_ARRAY);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
